[rtl/core/afs_pkg.sv]
// Shared types, constants and the CRC step function of the addressed frame slave.
`timescale 1ns / 1ps
package afs_pkg;

   localparam logic [7:0]  START_REQ_BYTE = 8'h3F;
   localparam logic [7:0]  START_RES_BYTE = 8'h2A;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_CRC_BAD = 2'd2;

   localparam logic [1:0] REG_OWN_ADDRESS     = 2'd0;
   localparam logic [1:0] REG_READ_PORT_CODE  = 2'd1;
   localparam logic [1:0] REG_WRITE_PORT_CODE = 2'd2;

   // one received frame, already checked against its CRC
   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] dest_address;
      logic [7:0] function_code;
      logic [7:0] payload;
      logic       crc_ok;
   } job_type;

   typedef struct packed {
      logic [7:0] own_address;
      logic [7:0] read_port_code;
      logic [7:0] write_port_code;
   } cfg_type;

   // feed one byte into a reflected CRC-16
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/core/afs_front.sv]
// Frame parser: accepts received bytes, tracks framing and checks the frame CRC.
`timescale 1ns / 1ps
module afs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   output logic               push,
   output afs_pkg::job_type   job
);
   import afs_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_ADDR = 3'd2;
   localparam logic [2:0] PH_FUNC = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_CRCH = 3'd5;
   localparam logic [2:0] PH_DONE = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  start_ff, start_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  crch_ff, crch_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_step;
   logic        is_start;

   assign crc_step = crc_feed(crc_ff, rx_byte);
   assign is_start = (rx_byte == START_REQ_BYTE) || (rx_byte == START_RES_BYTE);

   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      addr_in  = addr_ff;
      func_in  = func_ff;
      data_in  = data_ff;
      crch_in  = crch_ff;
      crc_in   = crc_ff;
      push     = 1'b0;
      if (accept) begin
         if (is_start) begin
            // restart framing wherever we are
            start_in = rx_byte;
            phase_in = PH_START;
            crc_in   = crc_feed(CRC_INIT, rx_byte);
         end else begin
            case (phase_ff)
               PH_START: begin
                  addr_in  = rx_byte;
                  crc_in   = crc_step;
                  phase_in = PH_ADDR;
               end
               PH_ADDR: begin
                  func_in  = rx_byte;
                  crc_in   = crc_step;
                  phase_in = PH_FUNC;
               end
               PH_FUNC: begin
                  data_in  = rx_byte;
                  crc_in   = crc_step;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  crch_in  = rx_byte;
                  phase_in = PH_CRCH;
               end
               PH_CRCH: begin
                  push     = 1'b1;
                  phase_in = PH_DONE;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   assign job.start_byte    = start_ff;
   assign job.dest_address  = addr_ff;
   assign job.function_code = func_ff;
   assign job.payload       = data_ff;
   assign job.crc_ok        = ({crch_ff, rx_byte} == crc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         start_ff <= 8'h00;
         addr_ff  <= 8'h00;
         func_ff  <= 8'h00;
         data_ff  <= 8'h00;
         crch_ff  <= 8'h00;
         crc_ff   <= CRC_INIT;
      end else begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         data_ff  <= data_in;
         crch_ff  <= crch_in;
         crc_ff   <= crc_in;
      end
   end

endmodule

[rtl/core/afs_queue.sv]
// Short queue of checked frames between the parser and the executor.
`timescale 1ns / 1ps
module afs_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  afs_pkg::job_type   push_job,
   input  logic               pop,
   output afs_pkg::job_type   head_job,
   output logic               full,
   output logic               empty
);
   import afs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? bump(wr_ff) : wr_ff;
      rd_in    = pop ? bump(rd_ff) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/core/afs_back.sv]
// Executor: runs the function of each frame and sends the response items.
`timescale 1ns / 1ps
module afs_back (
   input  logic               clock,
   input  logic               reset,
   input  afs_pkg::cfg_type   cfg,
   input  logic               q_empty,
   input  afs_pkg::job_type   q_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_tx_valid,
   output logic               rsp_last,
   output logic [1:0]         rsp_frame_status,
   output logic [2:0]         led_bits_out
);
   import afs_pkg::*;

   localparam logic [2:0] IDX_ADDR = 3'd1;
   localparam logic [2:0] IDX_FUNC = 3'd2;
   localparam logic [2:0] IDX_DATA = 3'd3;
   localparam logic [2:0] IDX_CRCH = 3'd4;
   localparam logic [2:0] IDX_CRCL = 3'd5;

   logic        busy_ff, busy_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  data_ff, data_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] crc_ff, crc_in;
   logic [2:0]  led_ff, led_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_txv_ff, out_txv_in;
   logic        out_last_ff, out_last_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic [2:0]  out_led_ff, out_led_in;

   logic        load_ok;
   logic [7:0]  start_n, data_n, sel_byte;
   logic [2:0]  led_n;
   logic [1:0]  status_n;

   assign load_ok = !out_valid_ff || rsp_ready;

   // function of the frame at the head of the queue
   always_comb begin
      start_n  = q_job.start_byte;
      data_n   = q_job.payload;
      led_n    = led_ff;
      status_n = ST_DONE;
      if (q_job.function_code == cfg.read_port_code) begin
         start_n = START_RES_BYTE;
         data_n  = {led_ff, 5'b00000};
      end else if (q_job.function_code == cfg.write_port_code) begin
         led_n   = q_job.payload[7:5];
         start_n = START_RES_BYTE;
         data_n  = 8'h00;
      end else begin
         status_n = ST_UNKNOWN;
      end
   end

   always_comb begin
      case (idx_ff)
         IDX_ADDR: sel_byte = addr_ff;
         IDX_FUNC: sel_byte = func_ff;
         IDX_DATA: sel_byte = data_ff;
         IDX_CRCH: sel_byte = crc_ff[15:8];
         IDX_CRCL: sel_byte = crc_ff[7:0];
         default:  sel_byte = 8'h00;
      endcase
   end

   always_comb begin
      busy_in       = busy_ff;
      idx_in        = idx_ff;
      addr_in       = addr_ff;
      func_in       = func_ff;
      data_in       = data_ff;
      status_in     = status_ff;
      crc_in        = crc_ff;
      led_in        = led_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_txv_in    = out_txv_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_led_in    = out_led_ff;
      pop           = 1'b0;
      if (load_ok) begin
         out_valid_in = 1'b0;
         if (busy_ff) begin
            out_valid_in  = 1'b1;
            out_byte_in   = sel_byte;
            out_txv_in    = 1'b1;
            out_last_in   = (idx_ff == IDX_CRCL);
            out_status_in = status_ff;
            out_led_in    = led_ff;
            // fold the header bytes into the response CRC as they go out
            if (idx_ff < IDX_CRCH) begin
               crc_in = crc_feed(crc_ff, sel_byte);
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_CRCL) begin
               busy_in = 1'b0;
            end
         end else if (!q_empty) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            out_byte_in  = 8'h00;
            out_txv_in   = 1'b0;
            out_last_in  = 1'b1;
            if (!q_job.crc_ok) begin
               out_status_in = ST_CRC_BAD;
               out_led_in    = led_ff;
            end else begin
               led_in        = led_n;
               out_status_in = status_n;
               out_led_in    = led_n;
               if (q_job.dest_address == cfg.own_address) begin
                  // send the start byte now, the rest follow one a cycle while the output can load
                  out_byte_in = start_n;
                  out_txv_in  = 1'b1;
                  out_last_in = 1'b0;
                  busy_in     = 1'b1;
                  idx_in      = IDX_ADDR;
                  addr_in     = q_job.dest_address;
                  func_in     = q_job.function_code;
                  data_in     = data_n;
                  status_in   = status_n;
                  crc_in      = crc_feed(CRC_INIT, start_n);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= IDX_ADDR;
         led_ff       <= 3'b000;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         led_ff       <= led_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      func_ff       <= func_in;
      data_ff       <= data_in;
      status_ff     <= status_in;
      crc_ff        <= crc_in;
      out_byte_ff   <= out_byte_in;
      out_txv_ff    <= out_txv_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      out_led_ff    <= out_led_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_tx_byte      = out_byte_ff;
   assign rsp_tx_valid     = out_txv_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_frame_status = out_status_ff;
   assign led_bits_out     = out_led_ff;

endmodule

[rtl/core/addressed_frame_slave_crc16_unit.sv]
// Top level of the addressed frame slave with CRC-16 check.
`timescale 1ns / 1ps
// Takes one received byte per cycle. A six-byte frame (start, address, function,
// data, CRC high, CRC low) is checked against a CRC-16 as its bytes arrive; at the
// last byte the frame enters a queue of QUEUE_DEPTH entries. The executor behind
// the queue runs the function and gives either one status item or six response
// items, one item per cycle from its output register while rsp_ready is high.
// Bytes are refused only while the queue is full. Registers: index 0 own address,
// 1 read function code, 2 write function code; write them only while idle.
module addressed_frame_slave_crc16_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_valid,
   output logic        rsp_last,
   output logic [1:0]  rsp_frame_status,
   output logic [2:0]  rsp_led_bits,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import afs_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type front_job, head_job;
   logic    push, pop, q_full, q_empty, accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_OWN_ADDRESS:     cfg_in.own_address     = csr_wdata;
            REG_READ_PORT_CODE:  cfg_in.read_port_code  = csr_wdata;
            REG_WRITE_PORT_CODE: cfg_in.write_port_code = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address     <= 8'd1;
         cfg_ff.read_port_code  <= 8'd1;
         cfg_ff.write_port_code <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   afs_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push),
      .job     (front_job)
   );

   afs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (front_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   afs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_job            (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_tx_valid     (rsp_tx_valid),
      .rsp_last         (rsp_last),
      .rsp_frame_status (rsp_frame_status),
      .led_bits_out     (rsp_led_bits)
   );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the addressed frame slave with CRC-16 check.
`timescale 1ns / 1ps
module testbench;
   import afs_pkg::*;

   localparam int         SETTLE_CYCLES = 16;
   localparam int         LONG_HOLD     = 300;
   localparam logic [1:0] REG_UNUSED    = 2'd3;
   localparam logic [7:0] RESET_OWN     = 8'd1;
   localparam logic [7:0] RESET_READ    = 8'd1;
   localparam logic [7:0] RESET_WRITE   = 8'd2;

   typedef enum logic [2:0] {
      P_IDLE, P_START, P_ADDR, P_FUNC, P_DATA, P_CRCH, P_DONE
   } parse_phase_type;

   typedef struct packed {
      logic       pause;
      logic [7:0] b;
   } feed_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       last;
      logic [1:0] status;
      logic [2:0] led;
   } reply_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_tx_valid;
   logic       rsp_last;
   logic [1:0] rsp_frame_status;
   logic [2:0] rsp_led_bits;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [7:0] csr_wdata = 8'h00;

   feed_type  rx_feed[$];
   reply_type awaited_replies[$];
   int        errors = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   bit        byte_taken = 1'b0;
   bit        long_hold = 1'b0;
   event      hold_start;

   // predictor state and its copy of the registers
   parse_phase_type p_phase = P_IDLE;
   logic [7:0]   p_start = 8'h00, p_addr = 8'h00, p_func = 8'h00;
   logic [7:0]   p_data = 8'h00, p_crc_hi = 8'h00;
   logic [2:0]   led_state = 3'd0;
   logic [7:0]   own_cfg = RESET_OWN, read_cfg = RESET_READ, write_cfg = RESET_WRITE;

   addressed_frame_slave_crc16_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_valid(rsp_tx_valid), .rsp_last(rsp_last),
      .rsp_frame_status(rsp_frame_status), .rsp_led_bits(rsp_led_bits),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) begin
         if (c[0])
            c = (c >> 1) ^ CRC_POLY;
         else
            c = c >> 1;
      end
      return c;
   endfunction

   function automatic logic [15:0] frame_crc(input logic [7:0] s, input logic [7:0] a,
                                             input logic [7:0] f, input logic [7:0] d);
      return crc16_step(crc16_step(crc16_step(crc16_step(CRC_INIT, s), a), f), d);
   endfunction

   function automatic void await_reply(input logic [7:0] b, input logic v, input logic l,
                                       input logic [1:0] st);
      reply_type r;
      r.tx_byte  = v ? b : 8'h00;
      r.tx_valid = v;
      r.last     = l;
      r.status   = st;
      r.led      = led_state;
      awaited_replies.push_back(r);
   endfunction

   // advance the frame parser by one byte and queue the replies it causes
   function automatic void frame_byte(input logic [7:0] b);
      logic [15:0] c;
      logic [1:0]  st;
      if (b == START_REQ_BYTE || b == START_RES_BYTE) begin
         p_start = b;
         p_phase = P_START;
         return;
      end
      case (p_phase)
         P_START: begin p_addr = b;   p_phase = P_ADDR; return; end
         P_ADDR:  begin p_func = b;   p_phase = P_FUNC; return; end
         P_FUNC:  begin p_data = b;   p_phase = P_DATA; return; end
         P_DATA:  begin p_crc_hi = b; p_phase = P_CRCH; return; end
         P_CRCH:  p_phase = P_DONE;
         default: return;
      endcase
      if ({p_crc_hi, b} != frame_crc(p_start, p_addr, p_func, p_data)) begin
         await_reply(8'h00, 1'b0, 1'b1, ST_CRC_BAD);
         return;
      end
      st = ST_DONE;
      if (p_func == read_cfg) begin
         p_start = START_RES_BYTE;
         p_data  = {led_state, 5'd0};
      end else if (p_func == write_cfg) begin
         led_state = p_data[7:5];
         p_start   = START_RES_BYTE;
         p_data    = 8'h00;
      end else begin
         st = ST_UNKNOWN;
      end
      if (p_addr != own_cfg) begin
         await_reply(8'h00, 1'b0, 1'b1, st);
         return;
      end
      c = frame_crc(p_start, p_addr, p_func, p_data);
      await_reply(p_start, 1'b1, 1'b0, st);
      await_reply(p_addr, 1'b1, 1'b0, st);
      await_reply(p_func, 1'b1, 1'b0, st);
      await_reply(p_data, 1'b1, 1'b0, st);
      await_reply(c[15:8], 1'b1, 1'b0, st);
      await_reply(c[7:0], 1'b1, 1'b1, st);
   endfunction

   // byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         byte_taken = 1'b0;
         if (rx_feed.size() > 0 && rx_feed[0].pause) begin
            // hold until every reply so far has been seen
            if (awaited_replies.size() == 0)
               void'(rx_feed.pop_front());
            req_valid <= 1'b0;
         end else if (rx_feed.size() == 0 || $urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_feed[0].b;
            void'(rx_feed.pop_front());
         end
      end
   end

   // reply receiver
   always @(negedge clock) begin
      rsp_ready <= !reset && !long_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      forever begin
         @(hold_start);
         @(posedge clock);
         long_hold = 1'b1;
         repeat (LONG_HOLD) @(posedge clock);
         long_hold = 1'b0;
      end
   end

   // monitor: register writes, reply checks, byte prediction
   always @(posedge clock) begin
      if (reset) begin
         p_phase = P_IDLE;
         p_start = 8'h00; p_addr = 8'h00; p_func = 8'h00; p_data = 8'h00; p_crc_hi = 8'h00;
         led_state = 3'd0;
         own_cfg = RESET_OWN; read_cfg = RESET_READ; write_cfg = RESET_WRITE;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_OWN_ADDRESS:     own_cfg   = csr_wdata;
               REG_READ_PORT_CODE:  read_cfg  = csr_wdata;
               REG_WRITE_PORT_CODE: write_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               $error("unexpected reply item: tx_byte %h", rsp_tx_byte);
               errors++;
            end else begin
               if (rsp_tx_byte !== awaited_replies[0].tx_byte) begin
                  $error("tx_byte: expected %h, got %h", awaited_replies[0].tx_byte,
                         rsp_tx_byte);
                  errors++;
               end
               if (rsp_tx_valid !== awaited_replies[0].tx_valid) begin
                  $error("tx_valid: expected %b, got %b", awaited_replies[0].tx_valid,
                         rsp_tx_valid);
                  errors++;
               end
               if (rsp_last !== awaited_replies[0].last) begin
                  $error("last: expected %b, got %b", awaited_replies[0].last, rsp_last);
                  errors++;
               end
               if (rsp_frame_status !== awaited_replies[0].status) begin
                  $error("frame_status: expected %0d, got %0d", awaited_replies[0].status,
                         rsp_frame_status);
                  errors++;
               end
               if (rsp_led_bits !== awaited_replies[0].led) begin
                  $error("led_bits: expected %0d, got %0d", awaited_replies[0].led,
                         rsp_led_bits);
                  errors++;
               end
               void'(awaited_replies.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            frame_byte(req_rx_byte);
            byte_taken = 1'b1;
         end
      end
   end

   task automatic add_byte(input logic [7:0] b);
      feed_type f;
      f.pause = 1'b0;
      f.b     = b;
      rx_feed.push_back(f);
   endtask

   task automatic add_pause();
      feed_type f;
      f.pause = 1'b1;
      f.b     = 8'h00;
      rx_feed.push_back(f);
   endtask

   // queue the first n bytes of a frame; a bad frame gets a damaged CRC
   task automatic add_frame(input logic [7:0] s, input logic [7:0] a, input logic [7:0] f,
                            input logic [7:0] d, input bit bad, input int n = 6);
      logic [15:0] c;
      logic [7:0]  bytes[6];
      c = frame_crc(s, a, f, d);
      if (bad)
         c = c ^ 16'($urandom_range(1, 16'hFFFF));
      bytes = '{s, a, f, d, c[15:8], c[7:0]};
      for (int k = 0; k < n; k++)
         add_byte(bytes[k]);
   endtask

   // mostly well-formed frames with random content, the rest noise and cut frames
   task automatic add_random_traffic(input int n_bytes);
      int          target, r;
      logic [7:0]  s, a, f;
      target = rx_feed.size() + n_bytes;
      while (rx_feed.size() < target) begin
         r = $urandom_range(99);
         s = $urandom_range(1) ? START_REQ_BYTE : START_RES_BYTE;
         a = ($urandom_range(99) < 60) ? own_cfg : 8'($urandom);
         case ($urandom_range(2))
            0: f = read_cfg;
            1: f = write_cfg;
            default: f = 8'($urandom);
         endcase
         if (r < 70)
            add_frame(s, a, f, 8'($urandom), $urandom_range(99) < 15);
         else if (r < 82)
            add_frame(s, a, f, 8'($urandom), 1'b0, $urandom_range(2, 5));
         else
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // wait for the block to drain, then give it time to finish any partial frame
   task automatic settle();
      while (rx_feed.size() != 0 || req_valid || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames under the reset register values
      add_byte(8'hFF);
      add_frame(START_REQ_BYTE, RESET_OWN, RESET_WRITE, 8'hFF, 1'b0);
      add_byte(8'h00);
      add_byte(START_REQ_BYTE);
      add_frame(START_RES_BYTE, 8'h80, RESET_READ, 8'h00, 1'b0);
      add_frame(START_REQ_BYTE, RESET_OWN, 8'hFF, 8'h00, 1'b0);
      add_frame(START_REQ_BYTE, RESET_OWN, RESET_READ, 8'h5C, 1'b1);
      settle();

      // no idling; long receiver hold-off so that the input stalls
      write_reg(REG_OWN_ADDRESS, 8'h00);
      write_reg(REG_READ_PORT_CODE, 8'hFF);
      write_reg(REG_WRITE_PORT_CODE, 8'h00);
      write_reg(REG_UNUSED, 8'hA5);
      @(posedge clock);
      -> hold_start;
      add_frame(START_REQ_BYTE, 8'h00, 8'h00, 8'hA0, 1'b0);
      add_frame(START_RES_BYTE, 8'h00, 8'hFF, 8'h13, 1'b0);
      add_frame(START_REQ_BYTE, 8'h00, 8'h77, 8'hFF, 1'b0);
      add_frame(START_REQ_BYTE, 8'h00, 8'hFF, 8'h00, 1'b0);
      add_random_traffic(12);
      add_pause();
      add_random_traffic(6);
      settle();

      // sender mostly idle
      write_reg(REG_OWN_ADDRESS, 8'hFF);
      write_reg(REG_READ_PORT_CODE, 8'h00);
      write_reg(REG_WRITE_PORT_CODE, 8'hFF);
      @(posedge clock);
      send_idle_pct = 78;
      add_random_traffic(12);
      settle();

      // receiver mostly stalling; read and write share one code
      write_reg(REG_OWN_ADDRESS, 8'h5A);
      write_reg(REG_READ_PORT_CODE, 8'h33);
      write_reg(REG_WRITE_PORT_CODE, 8'h33);
      @(posedge clock);
      send_idle_pct  = 0;
      recv_stall_pct = 78;
      add_random_traffic(12);
      settle();

      // both sides idling now and then
      write_reg(REG_OWN_ADDRESS, 8'($urandom));
      write_reg(REG_READ_PORT_CODE, 8'($urandom));
      write_reg(REG_WRITE_PORT_CODE, 8'($urandom));
      @(posedge clock);
      send_idle_pct  = 30;
      recv_stall_pct = 30;
      add_random_traffic(6);
      add_pause();
      add_random_traffic(6);
      settle();

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[sim.f]
rtl/core/afs_pkg.sv
rtl/core/afs_front.sv
rtl/core/afs_queue.sv
rtl/core/afs_back.sv
rtl/core/addressed_frame_slave_crc16_unit.sv
sim/testbench.sv
